// File: rtl/tbb_pkg.sv
// Shared types, widths and constants for the token bucket byte budget.
`default_nettype none

package tbb_pkg;

  localparam int BURST_SECONDS  = 2;
  localparam int TIME_FRAC_BITS = 10;

  localparam int RATE_W  = 32;
  localparam int CAP_W   = 48;
  localparam int TOK_W   = 48;
  localparam int TIME_W  = 40;
  localparam int BYTES_W = 32;
  localparam int CFG_W   = 48;

  // Elapsed ticks at which the bucket is certain to be full.
  localparam int ELAPSED_LIM = BURST_SECONDS << TIME_FRAC_BITS;
  localparam int EL_W        = $clog2(ELAPSED_LIM + 1);
  localparam int PROD_W      = EL_W + RATE_W;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_CHECK   = 2'd1,
    OP_SPEND   = 2'd2,
    OP_REFUND  = 2'd3
  } op_t;

  typedef enum logic {
    REG_BYTE_RATE   = 1'b0,
    REG_SESSION_CAP = 1'b1
  } reg_index_t;

  typedef struct packed {
    op_t                 opcode;
    logic [TIME_W-1:0]   time_stamp;
    logic [BYTES_W-1:0]  byte_count;
  } item_t;

  typedef struct packed {
    logic                accepted;
    logic [TOK_W-1:0]    tokens_held;
    logic [TOK_W-1:0]    spent_total;
    logic                cap_reached;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tbb_budget.sv
// Bucket state and the combinational next-state logic for one operation.
`default_nettype none

module tbb_budget (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire tbb_pkg::item_t               item,
  input  wire logic [tbb_pkg::RATE_W-1:0]   byte_rate,
  input  wire logic [tbb_pkg::CAP_W-1:0]    session_cap,
  output tbb_pkg::result_t                  result
);

  logic [tbb_pkg::TOK_W-1:0]  tokens, tokens_next;
  logic [tbb_pkg::TOK_W-1:0]  spent, spent_next;
  logic [tbb_pkg::TIME_W-1:0] last_time, last_time_next;
  logic                       started, started_next;

  logic [tbb_pkg::TOK_W-1:0]    burst;
  logic [tbb_pkg::TOK_W-1:0]    tok_clamped;
  logic [tbb_pkg::TIME_W-1:0]   elapsed;
  logic                         backwards;
  logic                         long_gap;
  logic [tbb_pkg::PROD_W-1:0]   prod;
  logic [tbb_pkg::TOK_W:0]      accrue_sum;
  logic [tbb_pkg::TOK_W:0]      spend_sum;
  logic [tbb_pkg::TOK_W:0]      refund_tok_sum;
  logic [tbb_pkg::TOK_W-1:0]    bytes_ext;
  logic                         cap_hit_now;
  logic                         over_cap;
  logic                         may_spend;
  logic                         acc;

  always_comb begin
    burst       = tbb_pkg::TOK_W'(byte_rate) * tbb_pkg::TOK_W'(tbb_pkg::BURST_SECONDS);
    tok_clamped = (tokens > burst) ? burst : tokens;
    bytes_ext   = tbb_pkg::TOK_W'(item.byte_count);

    elapsed   = item.time_stamp - last_time;
    backwards = item.time_stamp < last_time;
    long_gap  = elapsed >= tbb_pkg::TIME_W'(tbb_pkg::ELAPSED_LIM);
    // elapsed fits EL_W bits whenever the product is used
    prod = tbb_pkg::PROD_W'(elapsed[tbb_pkg::EL_W-1:0]) * tbb_pkg::PROD_W'(byte_rate);
    accrue_sum = {1'b0, tok_clamped}
               + (tbb_pkg::TOK_W+1)'(prod[tbb_pkg::PROD_W-1:tbb_pkg::TIME_FRAC_BITS]);

    cap_hit_now = (session_cap != '0) && (spent >= session_cap);
    spend_sum   = {1'b0, spent} + {1'b0, bytes_ext};
    over_cap    = (session_cap != '0) && (spend_sum > {1'b0, session_cap});
    may_spend   = (byte_rate != '0) && (item.byte_count != '0) && !cap_hit_now
                && !over_cap && (tok_clamped >= bytes_ext);
    refund_tok_sum = {1'b0, tok_clamped} + {1'b0, bytes_ext};

    acc            = 1'b0;
    tokens_next    = tok_clamped;
    spent_next     = spent;
    last_time_next = last_time;
    started_next   = started;

    unique case (item.opcode)
      tbb_pkg::OP_ADVANCE: begin
        last_time_next = item.time_stamp;
        started_next   = 1'b1;
        if (started && !backwards) begin
          if (byte_rate == '0) begin
            tokens_next = '0;
          end else if (long_gap) begin
            tokens_next = burst;
          end else if (accrue_sum > {1'b0, burst}) begin
            tokens_next = burst;
          end else begin
            tokens_next = accrue_sum[tbb_pkg::TOK_W-1:0];
          end
        end
      end
      tbb_pkg::OP_CHECK: begin
        acc = may_spend;
      end
      tbb_pkg::OP_SPEND: begin
        if (may_spend) begin
          acc         = 1'b1;
          tokens_next = tok_clamped - bytes_ext;
          spent_next  = spend_sum[tbb_pkg::TOK_W] ? '1 : spend_sum[tbb_pkg::TOK_W-1:0];
        end
      end
      tbb_pkg::OP_REFUND: begin
        spent_next  = (spent > bytes_ext) ? (spent - bytes_ext) : '0;
        tokens_next = (refund_tok_sum > {1'b0, burst}) ? burst
                    : refund_tok_sum[tbb_pkg::TOK_W-1:0];
      end
      default: ;
    endcase

    result.accepted    = acc;
    result.tokens_held = tokens_next;
    result.spent_total = spent_next;
    result.cap_reached = (session_cap != '0) && (spent_next >= session_cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tokens    <= '0;
      spent     <= '0;
      last_time <= '0;
      started   <= 1'b0;
    end else if (fire) begin
      tokens    <= tokens_next;
      spent     <= spent_next;
      last_time <= last_time_next;
      started   <= started_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_only_check_spend: assert property (@(posedge clk) disable iff (rst)
    fire && result.accepted |-> (item.opcode == tbb_pkg::OP_CHECK)
                                || (item.opcode == tbb_pkg::OP_SPEND))
    else $error("accepted flag on advance or refund");

  a_tokens_within_burst: assert property (@(posedge clk) disable iff (rst)
    fire |=> tokens <= $past(burst))
    else $error("credit above burst after a step");

  a_advance_starts: assert property (@(posedge clk) disable iff (rst)
    fire && (item.opcode == tbb_pkg::OP_ADVANCE) |=> started
                                                   && (last_time == $past(item.time_stamp)))
    else $error("advance did not record time");

  a_check_no_change: assert property (@(posedge clk) disable iff (rst)
    fire && (item.opcode == tbb_pkg::OP_CHECK) |=> $stable(spent) && $stable(last_time))
    else $error("check changed session state");
`endif

endmodule

`default_nettype wire

// File: rtl/token_bucket_byte_budget.sv
// Token bucket byte budget top level: config registers, input stage, result stage.
`default_nettype none

// Token bucket byte budget with a session cap. Each transfer on the slave side
// carries one operation (advance time, check, spend, refund) and yields exactly one
// result transfer on the master side. Throughput is one operation per cycle while
// m_tready does not hold a result back, set by the combinational bucket update.
// An operation passes through the input register, then the bucket update with
// its single elapsed-time by rate multiply into the result register. Each cycle
// that m_tready holds a result back also holds back the input.
// The bucket state updates as an operation leaves the input register, so back to
// back operations see each other's effects. Write byte_rate (index 0) and
// session_cap (index 1) only while no operation is in flight.
module token_bucket_byte_budget (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration writes
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [tbb_pkg::CFG_W-1:0]    cfg_data,
  // operations in
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [71:0]                  s_tdata,   // time_stamp[39:0], byte_count[71:40]
  input  wire logic [1:0]                   s_tuser,   // opcode[1:0]
  // results out
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [103:0]                      m_tdata    // accepted[0], tokens_held[48:1],
                                                       // spent_total[96:49],
                                                       // cap_reached[97], zero pad
);

  logic [tbb_pkg::RATE_W-1:0] byte_rate;
  logic [tbb_pkg::CAP_W-1:0]  session_cap;

  tbb_pkg::item_t   in_item;
  logic             in_valid;
  tbb_pkg::result_t step_result;
  tbb_pkg::result_t out_result;
  logic             out_free;
  logic             fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_rate   <= '0;
      session_cap <= '0;
    end else if (cfg_we) begin
      unique case (tbb_pkg::reg_index_t'(cfg_index))
        tbb_pkg::REG_BYTE_RATE:   byte_rate   <= cfg_data[tbb_pkg::RATE_W-1:0];
        tbb_pkg::REG_SESSION_CAP: session_cap <= cfg_data[tbb_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.opcode     <= tbb_pkg::op_t'(s_tuser);
      in_item.time_stamp <= s_tdata[tbb_pkg::TIME_W-1:0];
      in_item.byte_count <= s_tdata[tbb_pkg::TIME_W +: tbb_pkg::BYTES_W];
    end
  end

  tbb_budget u_budget (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (in_item),
    .byte_rate   (byte_rate),
    .session_cap (session_cap),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {6'd0, out_result.cap_reached, out_result.spent_total,
                    out_result.tokens_held, out_result.accepted};

endmodule

`default_nettype wire

// File: tb/tbb_budget_checker.sv
// Checker for the token bucket byte budget: predicts each result and compares transfers.
module tbb_budget_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [tbb_pkg::CFG_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [71:0]               s_tdata,   // time_stamp[39:0], byte_count[71:40]
  input  logic [1:0]                s_tuser,   // opcode[1:0]
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [103:0]              m_tdata,   // accepted[0], tokens_held[48:1],
                                               // spent_total[96:49],
                                               // cap_reached[97], zero pad
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SPENT_MAX = 64'hFFFF_FFFF_FFFF;

  logic [63:0] rate_q;
  logic [63:0] cap_q;
  logic [63:0] tok_q;
  logic [63:0] spent_q;
  logic [63:0] last_q;
  bit          started_q;

  tbb_pkg::result_t budget_results_due[$];
  tbb_pkg::result_t got;
  tbb_pkg::result_t want;
  tbb_pkg::result_t predicted;

  function automatic bit spend_allowed(logic [63:0] nb);
    if (rate_q == 0 || nb == 0) return 1'b0;
    if (cap_q != 0 && spent_q >= cap_q) return 1'b0;
    if (cap_q != 0 && spent_q + nb > cap_q) return 1'b0;
    return tok_q >= nb;
  endfunction

  function automatic tbb_pkg::result_t bucket_predict(tbb_pkg::op_t op, logic [63:0] ts,
                                                      logic [63:0] nb);
    logic [63:0] burst;
    logic [63:0] elapsed;
    tbb_pkg::result_t r;
    burst = rate_q * tbb_pkg::BURST_SECONDS;
    r.accepted = 1'b0;
    // a lowered rate bites here, before the operation
    if (tok_q > burst) tok_q = burst;
    case (op)
      tbb_pkg::OP_ADVANCE: begin
        if (!started_q) begin
          last_q = ts;
          started_q = 1'b1;
        end else if (ts < last_q) begin
          last_q = ts;
        end else begin
          elapsed = ts - last_q;
          last_q = ts;
          if (rate_q == 0) begin
            tok_q = 0;
          end else if (elapsed >= (64'(tbb_pkg::BURST_SECONDS) << tbb_pkg::TIME_FRAC_BITS)) begin
            tok_q = burst;
          end else begin
            tok_q = tok_q + ((elapsed * rate_q) >> tbb_pkg::TIME_FRAC_BITS);
            if (tok_q > burst) tok_q = burst;
          end
        end
      end
      tbb_pkg::OP_CHECK: begin
        r.accepted = spend_allowed(nb);
      end
      tbb_pkg::OP_SPEND: begin
        if (spend_allowed(nb)) begin
          r.accepted = 1'b1;
          tok_q = tok_q - nb;
          spent_q = spent_q + nb;
          if (spent_q > SPENT_MAX) spent_q = SPENT_MAX;
        end
      end
      default: begin
        spent_q = (spent_q > nb) ? spent_q - nb : 64'd0;
        tok_q = tok_q + nb;
        if (tok_q > burst) tok_q = burst;
      end
    endcase
    r.tokens_held = tok_q[tbb_pkg::TOK_W-1:0];
    r.spent_total = spent_q[tbb_pkg::TOK_W-1:0];
    r.cap_reached = (cap_q != 0) && (spent_q >= cap_q);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rate_q = 0;
      cap_q = 0;
      tok_q = 0;
      spent_q = 0;
      last_q = 0;
      started_q = 1'b0;
      budget_results_due.delete();
    end else begin
      // compare first: a result can never answer this edge's input
      if (m_tvalid && m_tready) begin
        got.accepted    = m_tdata[0];
        got.tokens_held = m_tdata[48:1];
        got.spent_total = m_tdata[96:49];
        got.cap_reached = m_tdata[97];
        if (budget_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: acc=%0d tok=%0d spent=%0d cap=%0d",
                     got.accepted, got.tokens_held, got.spent_total, got.cap_reached);
        end else begin
          want = budget_results_due[0];
          budget_results_due.delete(0);
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp acc=%0d tok=%0d spent=%0d cap=%0d,",
                        " got acc=%0d tok=%0d spent=%0d cap=%0d"},
                       want.accepted, want.tokens_held, want.spent_total, want.cap_reached,
                       got.accepted, got.tokens_held, got.spent_total, got.cap_reached);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == tbb_pkg::REG_BYTE_RATE)
          rate_q = {32'd0, cfg_data[tbb_pkg::RATE_W-1:0]};
        else
          cap_q = {16'd0, cfg_data};
      end
      if (s_tvalid && s_tready) begin
        predicted = bucket_predict(tbb_pkg::op_t'(s_tuser), {24'd0, s_tdata[39:0]},
                                   {32'd0, s_tdata[71:40]});
        budget_results_due.insert(budget_results_due.size(), predicted);
      end
    end
    outstanding = budget_results_due.size();
  end

endmodule

// File: tb/tb_token_bucket_byte_budget.sv
// Testbench top for the token bucket byte budget: stimulus, back pressure and verdict.
module tb_token_bucket_byte_budget;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASES = 8;
  localparam int PHASE_OPS = 125;
  localparam int FULL_ROUNDS = 16;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = 1'b0;
  logic [tbb_pkg::CFG_W-1:0] cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [71:0]               s_tdata = '0;
  logic [1:0]                s_tuser = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [103:0]              m_tdata;

  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  bit          calm = 1'b0;
  logic [39:0] now_ticks = '0;
  logic [31:0] cur_rate = '0;

  token_bucket_byte_budget i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  tbb_budget_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_backpressure
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  task automatic send_op(tbb_pkg::op_t op, logic [39:0] ts, logic [31:0] nb);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {nb, ts};
    do @(posedge clk); while (!s_tready);
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // only while nothing is in flight
  task automatic write_reg(tbb_pkg::reg_index_t idx, logic [tbb_pkg::CFG_W-1:0] val);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == tbb_pkg::REG_BYTE_RATE) cur_rate = val[tbb_pkg::RATE_W-1:0];
  endtask

  task automatic set_rate(logic [31:0] rate);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    write_reg(tbb_pkg::REG_BYTE_RATE, {junk, rate});
  endtask

  task automatic random_op();
    int pick;
    tbb_pkg::op_t op;
    logic [63:0] r64;
    logic [39:0] ts;
    logic [31:0] nb;
    pick = $urandom_range(0, 99);
    op = (pick < 35) ? tbb_pkg::OP_ADVANCE
       : (pick < 55) ? tbb_pkg::OP_CHECK
       : (pick < 85) ? tbb_pkg::OP_SPEND
       : tbb_pkg::OP_REFUND;
    r64 = {$urandom, $urandom};
    ts = r64[39:0];
    if (op == tbb_pkg::OP_ADVANCE) begin
      case ($urandom_range(0, 19))
        0: now_ticks = now_ticks >> 1;
        1: now_ticks = now_ticks + 2048 + $urandom_range(0, 5000);
        2: now_ticks = r64[39:0];
        default: now_ticks = now_ticks + $urandom_range(0, 600);
      endcase
      ts = now_ticks;
    end
    case ($urandom_range(0, 9))
      0: nb = '0;
      1: nb = '1;
      2: nb = $urandom;
      default: nb = $urandom_range(1, (cur_rate == 0) ? 32'd1000 : cur_rate);
    endcase
    send_op(op, ts, nb);
  endtask

  initial begin : stimulus
    logic [31:0] rates [PHASES];
    logic [47:0] caps [PHASES];
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    rates = '{32'd1000, $urandom, 32'hFFFF_FFFF, 32'd100, 32'd0, 32'd1, 32'd50000, $urandom};
    caps  = '{48'd0, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd0, 48'd0, 48'd1,
              48'($urandom_range(0, 1 << 20)), r64[47:0]};
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // zero rate out of reset
    send_op(tbb_pkg::OP_CHECK, 40'd0, 32'd5);
    send_op(tbb_pkg::OP_ADVANCE, 40'd100, 32'd0);   // first advance only records time
    send_op(tbb_pkg::OP_ADVANCE, 40'd200, 32'd0);   // zero rate clears credit
    send_op(tbb_pkg::OP_REFUND, 40'd0, 32'd7);
    set_rate(32'd1024);
    write_reg(tbb_pkg::REG_SESSION_CAP, 48'd0);
    send_op(tbb_pkg::OP_ADVANCE, 40'd1224, 32'd0);
    send_op(tbb_pkg::OP_CHECK, 40'd0, 32'd0);
    send_op(tbb_pkg::OP_CHECK, 40'd0, 32'd1024);
    send_op(tbb_pkg::OP_CHECK, 40'd0, 32'd1025);
    send_op(tbb_pkg::OP_SPEND, 40'd0, 32'd1000);
    send_op(tbb_pkg::OP_REFUND, 40'd0, 32'd400);
    send_op(tbb_pkg::OP_REFUND, 40'd0, 32'd5000);   // spent floors, credit clips to burst
    send_op(tbb_pkg::OP_ADVANCE, 40'd50, 32'd0);    // time steps back
    send_op(tbb_pkg::OP_ADVANCE, 40'd4050, 32'd0);  // long gap fills the bucket
    send_op(tbb_pkg::OP_ADVANCE, 40'hFF_FFFF_FFFF, 32'd0);
    send_op(tbb_pkg::OP_REFUND, 40'd0, 32'd0);
    send_op(tbb_pkg::OP_SPEND, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(tbb_pkg::REG_SESSION_CAP, 48'd3000);
    send_op(tbb_pkg::OP_SPEND, 40'd0, 32'd2048);
    send_op(tbb_pkg::OP_ADVANCE, 40'd0, 32'd0);
    send_op(tbb_pkg::OP_ADVANCE, 40'd2048, 32'd0);
    send_op(tbb_pkg::OP_SPEND, 40'd0, 32'd1000);    // would pass the cap
    send_op(tbb_pkg::OP_SPEND, 40'd0, 32'd952);     // lands exactly on the cap
    send_op(tbb_pkg::OP_CHECK, 40'd0, 32'd1);
    set_rate(32'd100);                              // lower rate clamps credit next step
    send_op(tbb_pkg::OP_CHECK, 40'd0, 32'd1);
    set_rate(32'd0);
    send_op(tbb_pkg::OP_ADVANCE, 40'd3000, 32'd0);
    send_op(tbb_pkg::OP_REFUND, 40'd0, 32'd3000);
    now_ticks = 40'd3000;

    for (int p = 0; p < PHASES; p++) begin
      set_rate(rates[p]);
      write_reg(tbb_pkg::REG_SESSION_CAP, caps[p]);
      calm = (p == 3 || p == 6);
      repeat (PHASE_OPS) random_op();
      calm = 1'b0;
    end

    // uncapped run at full rate with the largest spends
    calm = 1'b1;
    set_rate(32'hFFFF_FFFF);
    write_reg(tbb_pkg::REG_SESSION_CAP, 48'd0);
    for (int k = 0; k < FULL_ROUNDS; k++) begin
      now_ticks = now_ticks + 4096;
      send_op(tbb_pkg::OP_ADVANCE, now_ticks, 32'd0);
      send_op(tbb_pkg::OP_SPEND, 40'd0, 32'hFFFF_FFFF);
      send_op(tbb_pkg::OP_SPEND, 40'd0, 32'hFFFF_FFFF);
    end
    calm = 1'b0;
    send_op(tbb_pkg::OP_REFUND, 40'd0, 32'hFFFF_FFFF);
    send_op(tbb_pkg::OP_CHECK, 40'd0, 32'd1);
    write_reg(tbb_pkg::REG_SESSION_CAP, 48'hFFFF_FFFF_FFFF);
    send_op(tbb_pkg::OP_SPEND, 40'd0, 32'd1);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
